### rtl/core/rptla_pkg.sv
// package for the ranging peer table: sizes, command and status codes, types
// no dependencies
package rptla_pkg;

   localparam int MaxPeers = 16;
   localparam int MaxNbrs = 8;
   localparam int PeerIdxW = $clog2(MaxPeers);
   localparam int NbrIdxW = $clog2(MaxNbrs);
   localparam int PeerCntW = $clog2(MaxPeers + 1);
   localparam int NbrCntW = $clog2(MaxNbrs + 1);
   localparam int NbrAddrW = PeerIdxW + NbrIdxW;
   localparam logic [31:0] TimeoutReset = 32'd10000000;

   // register addresses on the csr port
   localparam logic [1:0] REG_TIMEOUT = 2'd0;

   localparam logic [1:0] CMD_ROUND = 2'd0;
   localparam logic [1:0] CMD_REPORT = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   localparam logic [2:0] ST_UPDATED = 3'd0;
   localparam logic [2:0] ST_INSERTED = 3'd1;
   localparam logic [2:0] ST_REPLACED = 3'd2;
   localparam logic [2:0] ST_REJECTED = 3'd3;
   localparam logic [2:0] ST_BAD_INDEX = 3'd4;
   localparam logic [2:0] ST_ROUND_DONE = 3'd5;

   typedef struct packed {
      logic [1:0] command;
      logic [47:0] now_us;
      logic [23:0] peer_id;
      logic signed [31:0] peer_distance;
      logic [7:0] peer_sequence;
      logic [23:0] neighbour_id;
      logic [15:0] neighbour_distance;
      logic [15:0] nlos_level;
      logic [3:0] entry_index;
      logic [2:0] neighbour_index;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [4:0] peer_count;
      logic [23:0] read_id;
      logic signed [31:0] read_distance;
      logic [7:0] read_sequence;
      logic [47:0] read_last_seen;
      logic [7:0] read_round;
      logic [15:0] read_nlos;
      logic [3:0] read_neighbour_count;
      logic [23:0] read_neighbour_id;
      logic [15:0] read_neighbour_distance;
   } rsp_type;

   // one peer record without its neighbours
   typedef struct packed {
      logic [23:0] id;
      logic [31:0] dist_mm;
      logic [7:0] seq;
      logic [47:0] seen;
      logic [7:0] round;
      logic [15:0] nlos;
      logic [NbrCntW-1:0] ncnt;
   } peer_type;

   typedef struct packed {
      logic [23:0] id;
      logic [15:0] dist_mm;
   } nbr_type;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_SCAN_CHK, S_PLACE, S_NSCAN, S_NSCAN_CHK,
      S_SWEEP, S_SWEEP_CHK, S_COPY, S_READ, S_READ_N, S_DONE
   } state_type;

endpackage

### rtl/core/rptla_cmp.sv
// shared compare unit: equality of ids and 48-bit subtract for order and age tests
// depends on rptla_pkg
module rptla_cmp (
   input  logic [47:0] a,
   input  logic [47:0] b,
   input  logic [31:0] limit,
   output logic        equal,
   output logic        a_less,
   output logic        aged
);
   import rptla_pkg::*;
   logic [48:0] diff;
   // one wide subtract serves less-than and idle age
   assign diff = {1'b0, a} - {1'b0, b};
   assign a_less = diff[48];
   assign equal = (a == b);
   assign aged = (diff[47:0] > {16'd0, limit});
endmodule

### rtl/core/ranging_peer_table_lru_aging.sv
// top level of the ranging peer table with oldest-entry replacement and aging
// depends on rptla_pkg and rptla_cmp
//
// Requests enter on the req_ stream (tvalid/tready/tdata) and one response
// leaves on the rsp_ stream for each. The block handles one request at a
// time: req_tready is high only while idle with no response waiting. A report
// scans the peer table one slot at a time (read, then compare) and then the
// neighbour list the same way. A round sweeps all peers; each kept peer that
// moves down is copied with its 8 neighbours. Age and order tests share one
// 48-bit compare/subtract unit; the tables sit in registered-read memories.
// The response is held in an output register until rsp_tready; the next
// request is taken in the cycle after the response leaves. Reset clears the
// peer count, the round counter and the control state and sets the idle
// timeout to 10000000 us; table memory is not cleared. csr_ is an APB-style
// port with the idle timeout at address 0.
module ranging_peer_table_lru_aging (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // command, now_us, peer_id, peer_distance, peer_sequence, neighbour_id,
   // neighbour_distance, nlos_level, entry_index, neighbour_index, zero pad
   input  logic [183:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status, peer_count, read_id, read_distance, read_sequence,
   // read_last_seen, read_round, read_nlos, read_neighbour_count,
   // read_neighbour_id, read_neighbour_distance, zero pad
   output logic [191:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [1:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import rptla_pkg::*;

   // peer and neighbour memories, registered reads
   peer_type peer_mem [MaxPeers];
   nbr_type  nbr_mem [MaxPeers*MaxNbrs];
   peer_type peer_rd_ff;
   nbr_type  nbr_rd_ff;
   logic [PeerIdxW-1:0] peer_ra, peer_wa;
   logic [NbrAddrW-1:0] nbr_ra, nbr_wa;
   logic peer_we, nbr_we;
   peer_type peer_wd;
   nbr_type  nbr_wd;

   always_ff @(posedge clock) begin
      if (peer_we) peer_mem[peer_wa] <= peer_wd;
      if (nbr_we) nbr_mem[nbr_wa] <= nbr_wd;
      peer_rd_ff <= peer_mem[peer_ra];
      nbr_rd_ff <= nbr_mem[nbr_ra];
   end

   // control and working registers
   state_type state_ff, state_in;
   logic [31:0] timeout_ff;
   logic [PeerCntW-1:0] total_ff, total_in;
   logic [7:0] round_ff, round_in;
   req_type req_ff, req_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [PeerCntW-1:0] idx_ff, idx_in;     // scan index
   logic [PeerCntW-1:0] keep_ff, keep_in;   // sweep write slot
   logic [NbrCntW-1:0] j_ff, j_in;         // neighbour index
   logic [PeerIdxW-1:0] old_ff, old_in;
   logic [47:0] old_seen_ff, old_seen_in;
   logic [PeerIdxW-1:0] slot_ff, slot_in;
   peer_type cur_ff, cur_in;                // record of the slot being written
   logic [2:0] st_ff, st_in;

   // shared compare unit
   logic [47:0] cmp_a, cmp_b;
   logic cmp_eq, cmp_lt, cmp_aged;
   rptla_cmp u_cmp (.a(cmp_a), .b(cmp_b), .limit(timeout_ff),
      .equal(cmp_eq), .a_less(cmp_lt), .aged(cmp_aged));

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {4'd0, rsp_ff.read_neighbour_distance, rsp_ff.read_neighbour_id,
      rsp_ff.read_neighbour_count, rsp_ff.read_nlos, rsp_ff.read_round,
      rsp_ff.read_last_seen, rsp_ff.read_sequence, rsp_ff.read_distance,
      rsp_ff.read_id, rsp_ff.peer_count, rsp_ff.status};
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_TIMEOUT) ? timeout_ff : 32'd0;

   // config register
   always_ff @(posedge clock) begin
      if (reset) timeout_ff <= TimeoutReset;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_TIMEOUT)
         timeout_ff <= csr_pwdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         total_ff <= '0;
         round_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         round_ff <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      idx_ff <= idx_in;
      keep_ff <= keep_in;
      j_ff <= j_in;
      old_ff <= old_in;
      old_seen_ff <= old_seen_in;
      slot_ff <= slot_in;
      cur_ff <= cur_in;
      st_ff <= st_in;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      total_in = total_ff;
      round_in = round_ff;
      req_in = req_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      idx_in = idx_ff;
      keep_in = keep_ff;
      j_in = j_ff;
      old_in = old_ff;
      old_seen_in = old_seen_ff;
      slot_in = slot_ff;
      cur_in = cur_ff;
      st_in = st_ff;
      peer_ra = idx_ff[PeerIdxW-1:0];
      nbr_ra = {slot_ff, j_ff[NbrIdxW-1:0]};
      peer_we = 1'b0;
      peer_wa = slot_ff;
      peer_wd = cur_ff;
      nbr_we = 1'b0;
      nbr_wa = {slot_ff, j_ff[NbrIdxW-1:0]};
      nbr_wd = {req_ff.neighbour_id, req_ff.neighbour_distance};
      cmp_a = 48'd0;
      cmp_b = 48'd0;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               req_in = req_tdata[176:0];
               req_in = {req_tdata[1:0], req_tdata[49:2], req_tdata[73:50],
                  req_tdata[105:74], req_tdata[113:106], req_tdata[137:114],
                  req_tdata[153:138], req_tdata[169:154], req_tdata[173:170],
                  req_tdata[176:174]};
               rsp_in = '0;
               idx_in = '0;
               keep_in = '0;
               old_in = '0;
               old_seen_in = '1;
               case (req_tdata[1:0])
                  CMD_ROUND: begin
                     round_in = round_ff + 8'd1;
                     state_in = S_SWEEP;
                  end
                  CMD_REPORT: begin
                     if (req_tdata[137:114] == req_tdata[73:50]) begin
                        st_in = ST_REJECTED;
                        state_in = S_DONE;
                     end else state_in = S_SCAN;
                  end
                  CMD_READ: begin
                     if ({1'b0, req_tdata[173:170]} < total_ff) begin
                        idx_in = PeerCntW'(req_tdata[173:170]);
                        state_in = S_READ;
                     end else begin
                        st_in = ST_BAD_INDEX;
                        state_in = S_DONE;
                     end
                  end
                  default: begin
                     st_in = ST_BAD_INDEX;
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         // report: look up the id, track the oldest slot
         S_SCAN: begin
            if (idx_ff >= total_ff) begin
               cur_in.dist_mm = req_ff.peer_distance;
               cur_in.seq = req_ff.peer_sequence;
               cur_in.seen = req_ff.now_us;
               cur_in.round = round_ff;
               cur_in.nlos = req_ff.nlos_level;
               cur_in.id = req_ff.peer_id;
               cur_in.ncnt = '0;
               if (total_ff >= PeerCntW'(MaxPeers)) begin
                  slot_in = old_ff;
                  st_in = ST_REPLACED;
               end else begin
                  slot_in = total_ff[PeerIdxW-1:0];
                  total_in = total_ff + 1'b1;
                  st_in = ST_INSERTED;
               end
               state_in = S_PLACE;
            end else state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            cmp_a = peer_rd_ff.seen;
            cmp_b = old_seen_ff;
            if (peer_rd_ff.id == req_ff.peer_id) begin
               cur_in = peer_rd_ff;
               cur_in.dist_mm = req_ff.peer_distance;
               cur_in.seq = req_ff.peer_sequence;
               cur_in.seen = req_ff.now_us;
               cur_in.round = round_ff;
               cur_in.nlos = req_ff.nlos_level;
               slot_in = idx_ff[PeerIdxW-1:0];
               st_in = ST_UPDATED;
               state_in = S_PLACE;
            end else begin
               if (idx_ff == '0 || cmp_lt) begin
                  old_in = idx_ff[PeerIdxW-1:0];
                  old_seen_in = peer_rd_ff.seen;
               end
               idx_in = idx_ff + 1'b1;
               state_in = S_SCAN;
            end
         end
         S_PLACE: begin
            j_in = '0;
            if (req_ff.neighbour_id == 24'd0) begin
               peer_we = 1'b1;
               state_in = S_DONE;
            end else state_in = S_NSCAN;
         end
         // neighbour lookup, update or append
         S_NSCAN: begin
            if (j_ff >= cur_ff.ncnt) begin
               if (cur_ff.ncnt < NbrCntW'(MaxNbrs)) begin
                  nbr_we = 1'b1;
                  cur_in.ncnt = cur_ff.ncnt + 1'b1;
               end
               state_in = S_DONE;
               peer_we = 1'b1;
               peer_wd = cur_ff;
               if (cur_ff.ncnt < NbrCntW'(MaxNbrs)) peer_wd.ncnt = cur_ff.ncnt + 1'b1;
            end else state_in = S_NSCAN_CHK;
         end
         S_NSCAN_CHK: begin
            cmp_a = {24'd0, nbr_rd_ff.id};
            cmp_b = {24'd0, req_ff.neighbour_id};
            if (cmp_eq) begin
               nbr_we = 1'b1;
               peer_we = 1'b1;
               state_in = S_DONE;
            end else begin
               j_in = j_ff + 1'b1;
               state_in = S_NSCAN;
            end
         end
         // round: drop aged peers, compact the rest
         S_SWEEP: begin
            if (idx_ff >= total_ff) begin
               total_in = keep_ff;
               st_in = ST_ROUND_DONE;
               state_in = S_DONE;
            end else state_in = S_SWEEP_CHK;
         end
         S_SWEEP_CHK: begin
            cmp_a = req_ff.now_us;
            cmp_b = peer_rd_ff.seen;
            if (cmp_aged) begin
               idx_in = idx_ff + 1'b1;
               state_in = S_SWEEP;
            end else if (keep_ff == idx_ff) begin
               keep_in = keep_ff + 1'b1;
               idx_in = idx_ff + 1'b1;
               state_in = S_SWEEP;
            end else begin
               peer_we = 1'b1;
               peer_wa = keep_ff[PeerIdxW-1:0];
               peer_wd = peer_rd_ff;
               slot_in = idx_ff[PeerIdxW-1:0];
               j_in = '0;
               state_in = S_COPY;
            end
         end
         S_COPY: begin
            // the write trails the read address by one neighbour index
            nbr_ra = {idx_ff[PeerIdxW-1:0], j_ff[NbrIdxW-1:0]};
            if (j_ff != '0) begin
               nbr_we = 1'b1;
               nbr_wa = {keep_ff[PeerIdxW-1:0], NbrIdxW'(j_ff - 1'b1)};
               nbr_wd = nbr_rd_ff;
            end
            if (j_ff == NbrCntW'(MaxNbrs)) begin
               keep_in = keep_ff + 1'b1;
               idx_in = idx_ff + 1'b1;
               state_in = S_SWEEP;
            end else j_in = j_ff + 1'b1;
         end
         // read: peer and neighbour fetched in the same cycle
         S_READ: begin
            nbr_ra = {idx_ff[PeerIdxW-1:0], req_ff.neighbour_index};
            slot_in = idx_ff[PeerIdxW-1:0];
            j_in = NbrCntW'(req_ff.neighbour_index);
            state_in = S_READ_N;
         end
         S_READ_N: begin
            state_in = S_DONE;
            st_in = ST_UPDATED;
            rsp_in.read_id = peer_rd_ff.id;
            rsp_in.read_distance = peer_rd_ff.dist_mm;
            rsp_in.read_sequence = peer_rd_ff.seq;
            rsp_in.read_last_seen = peer_rd_ff.seen;
            rsp_in.read_round = peer_rd_ff.round;
            rsp_in.read_nlos = peer_rd_ff.nlos;
            rsp_in.read_neighbour_count = 4'(peer_rd_ff.ncnt);
            if (j_ff < peer_rd_ff.ncnt) begin
               rsp_in.read_neighbour_id = nbr_rd_ff.id;
               rsp_in.read_neighbour_distance = nbr_rd_ff.dist_mm;
            end
         end
         S_DONE: begin
            rsp_in.status = st_ff;
            rsp_in.peer_count = 5'(total_ff);
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // a response is raised only from the final step
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == S_DONE)
      else $error("response without final step");
   // the table never holds more than its capacity
   a_total_cap: assert property (@(posedge clock) disable iff (reset)
      total_ff <= PeerCntW'(MaxPeers))
      else $error("peer count over capacity");
   // no request is taken while a response waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> !(req_tvalid && req_tready) || !rsp_tvalid)
      else $error("request taken under pending response");
endmodule

### bench/tb.sv
// self-checking testbench for the ranging peer table with oldest-entry
// replacement and aging; depends on rptla_pkg and ranging_peer_table_lru_aging
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rptla_pkg::*;

   localparam logic [1:0] CmdUnknown = 2'd3;
   localparam int NumDirected = 16;
   localparam int NumPhases = 5;
   localparam int PhaseItems = 240;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [183:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [191:0] rsp_tdata;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [1:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   ranging_peer_table_lru_aging u_dut (.*);

   always #5 clock = ~clock;

   // mirror of the peer table
   logic [23:0] pt_id[MaxPeers];
   logic [31:0] pt_dist[MaxPeers];
   logic [7:0]  pt_seq[MaxPeers];
   logic [47:0] pt_seen[MaxPeers];
   logic [7:0]  pt_round[MaxPeers];
   logic [15:0] pt_nlos[MaxPeers];
   logic [3:0]  pt_ncnt[MaxPeers];
   logic [23:0] nb_id[MaxPeers*MaxNbrs];
   logic [15:0] nb_dist[MaxPeers*MaxNbrs];
   int          peer_total = 0;
   logic [7:0]  round_ctr = '0;
   logic [31:0] idle_timeout = TimeoutReset;

   rsp_type expected_rsp[$];
   int      errors = 0;
   bit      calm = 1'b0;
   bit      long_hold = 1'b0;
   logic [47:0] now_clk = '0;

   function automatic req_type mk_req(logic [1:0] cmd, logic [47:0] now, logic [23:0] pid,
                                      logic [31:0] pdist, logic [7:0] seq, logic [23:0] nid,
                                      logic [15:0] ndist, logic [15:0] nlos,
                                      logic [3:0] eidx, logic [2:0] nidx);
      req_type r;
      r.command = cmd; r.now_us = now; r.peer_id = pid; r.peer_distance = pdist;
      r.peer_sequence = seq; r.neighbour_id = nid; r.neighbour_distance = ndist;
      r.nlos_level = nlos; r.entry_index = eidx; r.neighbour_index = nidx;
      return r;
   endfunction

   function automatic logic [183:0] pack_req(req_type r);
      return {7'b0, r.neighbour_index, r.entry_index, r.nlos_level, r.neighbour_distance,
              r.neighbour_id, r.peer_sequence, r.peer_distance, r.peer_id, r.now_us,
              r.command};
   endfunction

   // copy one peer with its neighbour list into a lower slot
   function automatic void move_peer(int dst, int src);
      pt_id[dst] = pt_id[src]; pt_dist[dst] = pt_dist[src]; pt_seq[dst] = pt_seq[src];
      pt_seen[dst] = pt_seen[src]; pt_round[dst] = pt_round[src];
      pt_nlos[dst] = pt_nlos[src]; pt_ncnt[dst] = pt_ncnt[src];
      for (int j = 0; j < MaxNbrs; j++) begin
         nb_id[dst*MaxNbrs+j] = nb_id[src*MaxNbrs+j];
         nb_dist[dst*MaxNbrs+j] = nb_dist[src*MaxNbrs+j];
      end
   endfunction

   // table update and response for one request
   function automatic rsp_type table_step(req_type r);
      rsp_type o;
      int keep, slot, oldest, n, base;
      bit found, hit;
      logic [47:0] idle;
      keep = 0; slot = 0; oldest = 0; found = 0; hit = 0;
      o = '0;
      o.status = ST_BAD_INDEX;
      if (r.command == CMD_ROUND) begin
         round_ctr = round_ctr + 8'd1;
         for (int i = 0; i < peer_total; i++) begin
            idle = r.now_us - pt_seen[i];
            if (idle > {16'b0, idle_timeout}) continue;
            if (keep != i) move_peer(keep, i);
            keep++;
         end
         peer_total = keep;
         o.status = ST_ROUND_DONE;
      end else if (r.command == CMD_REPORT) begin
         if (r.neighbour_id == r.peer_id) begin
            o.status = ST_REJECTED;
         end else begin
            for (int i = 0; i < peer_total; i++) begin
               if (pt_id[i] == r.peer_id) begin
                  slot = i; found = 1; break;
               end
               if (pt_seen[oldest] > pt_seen[i]) oldest = i;
            end
            if (found) begin
               o.status = ST_UPDATED;
            end else if (peer_total >= MaxPeers) begin
               slot = oldest; o.status = ST_REPLACED;
            end else begin
               slot = peer_total; peer_total++; o.status = ST_INSERTED;
            end
            if (!found) begin
               pt_id[slot] = r.peer_id; pt_ncnt[slot] = '0;
            end
            pt_dist[slot] = r.peer_distance; pt_seq[slot] = r.peer_sequence;
            pt_seen[slot] = r.now_us; pt_round[slot] = round_ctr;
            pt_nlos[slot] = r.nlos_level;
            // neighbour update or append, dropped when the list is full
            if (r.neighbour_id != 0) begin
               base = slot * MaxNbrs;
               n = pt_ncnt[slot];
               for (int j = 0; j < n; j++) begin
                  if (!hit && nb_id[base+j] == r.neighbour_id) begin
                     nb_dist[base+j] = r.neighbour_distance; hit = 1;
                  end
               end
               if (!hit && n < MaxNbrs) begin
                  nb_id[base+n] = r.neighbour_id;
                  nb_dist[base+n] = r.neighbour_distance;
                  pt_ncnt[slot] = n + 1;
               end
            end
         end
      end else if (r.command == CMD_READ) begin
         if (r.entry_index < peer_total) begin
            o.status = ST_UPDATED;
            o.read_id = pt_id[r.entry_index];
            o.read_distance = pt_dist[r.entry_index];
            o.read_sequence = pt_seq[r.entry_index];
            o.read_last_seen = pt_seen[r.entry_index];
            o.read_round = pt_round[r.entry_index];
            o.read_nlos = pt_nlos[r.entry_index];
            o.read_neighbour_count = pt_ncnt[r.entry_index];
            if (r.neighbour_index < pt_ncnt[r.entry_index]) begin
               o.read_neighbour_id = nb_id[r.entry_index*MaxNbrs + r.neighbour_index];
               o.read_neighbour_distance =
                  nb_dist[r.entry_index*MaxNbrs + r.neighbour_index];
            end
         end
      end
      o.peer_count = peer_total[4:0];
      return o;
   endfunction

   // offer one request and wait for it to be taken
   task automatic send_request(req_type r, bit has_gold, logic [2:0] gold_status,
                               logic [4:0] gold_count);
      rsp_type e;
      req_tvalid <= 1'b1;
      req_tdata <= pack_req(r);
      do @(posedge clock); while (!req_tready);
      e = table_step(r);
      if (has_gold) begin
         e.status = gold_status;
         e.peer_count = gold_count;
      end
      expected_rsp = {expected_rsp, e};
   endtask

   task automatic sender_gap();
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_timeout(logic [31:0] value);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= REG_TIMEOUT; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      idle_timeout = value;
      @(posedge clock);
   endtask

   // mostly well-formed traffic over a small id pool, some raw noise
   function automatic req_type random_request(int round_pct);
      req_type r;
      int pick;
      logic [23:0] pid;
      pick = $urandom_range(0, 99);
      now_clk = now_clk + $urandom_range(0, 600);
      pid = $urandom_range(1, 24);
      if (pick < 5) begin
         r = mk_req($urandom, {$urandom, $urandom}, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, $urandom);
         if ($urandom_range(0, 1)) now_clk = r.now_us;
      end else if (pick < 5 + round_pct) begin
         r = mk_req(CMD_ROUND, now_clk, pid, 0, 0, 0, 0, 0, 0, 0);
      end else if (pick < 75) begin
         r = mk_req(CMD_REPORT, now_clk, pid, $urandom, $urandom,
                    ($urandom_range(0, 19) == 0) ? pid :
                    ($urandom_range(0, 4) == 0) ? 24'd0 : 24'($urandom_range(1, 40)),
                    $urandom, $urandom, 0, 0);
      end else begin
         r = mk_req(CMD_READ, now_clk, 0, 0, 0, 0, 0, 0, $urandom_range(0, 15),
                    $urandom_range(0, 7));
      end
      return r;
   endfunction

   task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s expected %0h actual %0h", name, exp_v, act_v);
         errors++;
      end
   endtask

   // response checker
   always @(posedge clock) begin
      rsp_type e;
      if (rsp_tvalid && rsp_tready) begin
         if (expected_rsp.size() == 0) begin
            $error("response with none expected");
            errors++;
         end else begin
            e = expected_rsp.pop_front();
            check_field("status", e.status, rsp_tdata[2:0]);
            check_field("peer_count", e.peer_count, rsp_tdata[7:3]);
            check_field("read_id", e.read_id, rsp_tdata[31:8]);
            check_field("read_distance", {32'd0, e.read_distance}, rsp_tdata[63:32]);
            check_field("read_sequence", e.read_sequence, rsp_tdata[71:64]);
            check_field("read_last_seen", e.read_last_seen, rsp_tdata[119:72]);
            check_field("read_round", e.read_round, rsp_tdata[127:120]);
            check_field("read_nlos", e.read_nlos, rsp_tdata[143:128]);
            check_field("read_neighbour_count", e.read_neighbour_count, rsp_tdata[147:144]);
            check_field("read_neighbour_id", e.read_neighbour_id, rsp_tdata[171:148]);
            check_field("read_neighbour_distance", e.read_neighbour_distance,
                        rsp_tdata[187:172]);
         end
      end
   end

   // receiver stalls in bursts, one long hold-off on request
   initial begin
      forever begin
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end else if (calm) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            if ($urandom_range(0, 1)) begin
               rsp_tready <= 1'b0;
               repeat ($urandom_range(1, 16)) @(posedge clock);
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

   // main sequence
   initial begin
      req_type     dir_req[NumDirected];
      bit          dir_gold[NumDirected];
      logic [2:0]  dir_status[NumDirected];
      logic [4:0]  dir_count[NumDirected];
      logic [31:0] phase_timeout[NumPhases];
      int          round_pct;

      // directed table; gold status and count where obvious
      dir_req[0] = mk_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      dir_gold[0] = 1; dir_status[0] = ST_BAD_INDEX; dir_count[0] = 0;
      dir_req[1] = mk_req(CMD_ROUND, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      dir_gold[1] = 1; dir_status[1] = ST_ROUND_DONE; dir_count[1] = 0;
      dir_req[2] = mk_req(CmdUnknown, '1, '1, '1, '1, '1, '1, '1, '1, '1);
      dir_gold[2] = 1; dir_status[2] = ST_BAD_INDEX; dir_count[2] = 0;
      dir_req[3] = mk_req(CMD_REPORT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      dir_gold[3] = 1; dir_status[3] = ST_REJECTED; dir_count[3] = 0;
      dir_req[4] = mk_req(CMD_REPORT, 5, '1, 0, 0, '1, 0, 0, 0, 0);
      dir_gold[4] = 1; dir_status[4] = ST_REJECTED; dir_count[4] = 0;
      dir_req[5] = mk_req(CMD_REPORT, 100, 24'd1, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
      dir_gold[5] = 1; dir_status[5] = ST_INSERTED; dir_count[5] = 1;
      dir_req[6] = mk_req(CMD_REPORT, '1, '1, 32'h7fff_ffff, '1, 24'd1, '1, '1, 0, 0);
      dir_gold[6] = 1; dir_status[6] = ST_INSERTED; dir_count[6] = 2;
      dir_req[7] = mk_req(CMD_REPORT, 200, 24'd1, 32'd42, 8'd7, 24'd2, 16'd9, 16'd3, 0, 0);
      dir_gold[7] = 1; dir_status[7] = ST_UPDATED; dir_count[7] = 2;
      dir_req[8] = mk_req(CMD_REPORT, 210, 24'd1, 32'd43, 8'd8, 24'd2, 16'd11, 16'd4, 0, 0);
      dir_req[9] = mk_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 4'd0, 3'd0);
      dir_req[10] = mk_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 4'd1, 3'd7);
      dir_req[11] = mk_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 4'd15, 3'd0);
      dir_gold[11] = 1; dir_status[11] = ST_BAD_INDEX; dir_count[11] = 2;
      // time wrap: idle of the peer seen at the top of the range stays small
      dir_req[12] = mk_req(CMD_ROUND, 48'd5, 0, 0, 0, 0, 0, 0, 0, 0);
      dir_req[13] = mk_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 4'd0, 3'd0);
      dir_req[14] = mk_req(CMD_ROUND, 48'h0000_8000_0000, 0, 0, 0, 0, 0, 0, 0, 0);
      dir_gold[14] = 1; dir_status[14] = ST_ROUND_DONE; dir_count[14] = 0;
      dir_req[15] = mk_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 4'd0, 3'd0);
      dir_gold[15] = 1; dir_status[15] = ST_BAD_INDEX; dir_count[15] = 0;
      for (int i = 8; i < 14; i++)
         if (i != 11) dir_gold[i] = 0;
      dir_gold[15] = 1;

      phase_timeout[0] = TimeoutReset;
      phase_timeout[1] = 32'd1;
      phase_timeout[2] = 32'd1500;
      phase_timeout[3] = 32'hffff_ffff;
      phase_timeout[4] = $urandom_range(200, 5000);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_req[i]) begin
         send_request(dir_req[i], dir_gold[i], dir_status[i], dir_count[i]);
         sender_gap();
      end
      drain();

      for (int p = 0; p < NumPhases; p++) begin
         if (p != 0) write_timeout(phase_timeout[p]);
         round_pct = (p == 2) ? 45 : 15;
         calm = (p == NumPhases - 1);
         for (int k = 0; k < PhaseItems; k++) begin
            if (p == 1 && k == 100) long_hold = 1'b1;
            send_request(random_request(round_pct), 0, '0, '0);
            sender_gap();
         end
         drain();
      end

      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
